// ----- rtl/nta_pkg.sv -----
// ============================================================================
// nta_pkg: shared constants for the two-target track assigner
// Field widths, status codes, register map and reset values.
// ============================================================================
package nta_pkg;

    // Width of the per-frame centroid count.
    localparam int CNT_W = 4;

    // Width of the configuration data bus and the threshold register.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int THR_W      = 8;

    // Register map, word index.
    localparam logic REG_LOST_THRESHOLD = 1'b0;

    // Reset value of the lost threshold.
    localparam logic [THR_W-1:0] LOST_THRESHOLD_RESET = 8'd10;

    // Track status codes.
    localparam logic [1:0] ST_POSITION     = 2'd0;
    localparam logic [1:0] ST_LOST_NOW     = 2'd1;
    localparam logic [1:0] ST_MISSING      = 2'd2;
    localparam logic [1:0] ST_MISSING_LONG = 2'd3;

    // Centroid counts with a meaning of their own.
    localparam logic [CNT_W-1:0] CNT_NONE  = 4'd0;
    localparam logic [CNT_W-1:0] CNT_ONE   = 4'd1;
    localparam logic [CNT_W-1:0] CNT_TWO   = 4'd2;
    localparam logic [CNT_W-1:0] CNT_THREE = 4'd3;

endpackage

// ----- rtl/nta_frame_if.sv -----
// ============================================================================
// nta_frame_if: frame channel
// Carries one frame of centroids with a valid/ready handshake.
// ============================================================================
interface nta_frame_if
    import nta_pkg::*;
#(
    parameter int COORD_WIDTH = 15
);
    logic                   valid;
    logic                   ready;
    logic [CNT_W-1:0]       cluster_count;
    logic [COORD_WIDTH-1:0] c1_row;
    logic [COORD_WIDTH-1:0] c1_col;
    logic [COORD_WIDTH-1:0] c2_row;
    logic [COORD_WIDTH-1:0] c2_col;
    logic [COORD_WIDTH-1:0] c3_row;
    logic [COORD_WIDTH-1:0] c3_col;

    modport source (
        output valid, cluster_count, c1_row, c1_col, c2_row, c2_col, c3_row, c3_col,
        input  ready
    );

    modport sink (
        input  valid, cluster_count, c1_row, c1_col, c2_row, c2_col, c3_row, c3_col,
        output ready
    );
endinterface

// ----- rtl/nta_report_if.sv -----
// ============================================================================
// nta_report_if: report channel
// Carries one track report with a valid/ready handshake.
// ============================================================================
interface nta_report_if #(
    parameter int COORD_WIDTH = 15
);
    logic                   valid;
    logic                   ready;
    logic                   line_written;
    logic [1:0]             one_status;
    logic [COORD_WIDTH-1:0] one_row;
    logic [COORD_WIDTH-1:0] one_col;
    logic [1:0]             two_status;
    logic [COORD_WIDTH-1:0] two_row;
    logic [COORD_WIDTH-1:0] two_col;

    modport source (
        output valid, line_written, one_status, one_row, one_col,
               two_status, two_row, two_col,
        input  ready
    );

    modport sink (
        input  valid, line_written, one_status, one_row, one_col,
               two_status, two_row, two_col,
        output ready
    );
endinterface

// ----- rtl/two_target_nearest_track_assign_unit.sv -----
// ============================================================================
// two_target_nearest_track_assign_unit: nearest-neighbor two-track assigner
// Matches up to three centroids per frame to two tracks by squared distance
// and reports each track's status and position.
// ============================================================================
//
//  Channel    Direction  Handshake        Moves
//  ---------  ---------  ---------------  ----------------------------------
//  i_frame    in         valid / ready    one frame: count and 3 centroids
//  o_report   out        valid / ready    one report per frame
//  APB        in         psel / penable   lost_threshold register writes
//
//  Every frame yields exactly one report, loaded into the report register at
//  the edge at which the frame leaves the input register; a frame waits in
//  the input register while the report register is stalled. A frame is taken
//  in every cycle unless the report side stalls; the track state is updated
//  in a single pass from the input register to the report register, so that
//  loop sets the rate at one item per cycle. A stalled report holds the input
//  register, and i_frame.ready drops only when both registers are full.
//  Reset clears both tracks, both miss counters and the threshold to ten.
//
module two_target_nearest_track_assign_unit
    import nta_pkg::*;
#(
    parameter int COORD_WIDTH = 15,
    parameter int MISS_WIDTH  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nta_frame_if.sink             i_frame,
    nta_report_if.source          o_report,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int SQ_W   = 2 * COORD_WIDTH;
    localparam int DIST_W = SQ_W + 1;
    localparam int CMP_W  = (MISS_WIDTH > THR_W) ? MISS_WIDTH : THR_W;
    localparam logic [MISS_WIDTH-1:0] MISS_MAX = {MISS_WIDTH{1'b1}};

    typedef logic [COORD_WIDTH-1:0] t_coord;
    typedef logic [DIST_W-1:0]      t_dist;
    typedef logic [MISS_WIDTH-1:0]  t_miss;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic t_dist sq_dist(input t_coord r, input t_coord c,
                                      input t_coord tr, input t_coord tc);
        t_coord            dr;
        t_coord            dc;
        logic [SQ_W-1:0]   pr;
        logic [SQ_W-1:0]   pc;
        dr = (r >= tr) ? t_coord'(r - tr) : t_coord'(tr - r);
        dc = (c >= tc) ? t_coord'(c - tc) : t_coord'(tc - c);
        pr = SQ_W'(dr) * SQ_W'(dr);
        pc = SQ_W'(dc) * SQ_W'(dc);
        return DIST_W'(pr) + DIST_W'(pc);
    endfunction

    function automatic t_miss bump(input t_miss m);
        return (m == MISS_MAX) ? m : t_miss'(m + 1'b1);
    endfunction

    function automatic t_dist min2(input t_dist x, input t_dist y);
        return (x < y) ? x : y;
    endfunction

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [THR_W-1:0] r_thr;
    logic             cfg_hit;

    assign cfg_hit = (paddr[APB_ADDR_W-1:2] == REG_LOST_THRESHOLD);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? APB_DATA_W'(r_thr) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= LOST_THRESHOLD_RESET;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    function automatic logic [1:0] miss_status(input t_miss m,
                                               input logic [THR_W-1:0] thr);
        logic [CMP_W-1:0] mw;
        logic [CMP_W-1:0] tw;
        mw = CMP_W'(m);
        tw = CMP_W'(thr);
        if (mw == tw) begin
            return ST_LOST_NOW;
        end
        return (mw > tw) ? ST_MISSING_LONG : ST_MISSING;
    endfunction

    // ------------------------------------------------------------------
    // Input register and handshake
    // ------------------------------------------------------------------
    logic             r_in_vld;
    logic [CNT_W-1:0] r_cnt;
    t_coord           r_c1r, r_c1c, r_c2r, r_c2c, r_c3r, r_c3c;
    logic             r_out_vld;
    logic             advance;
    logic             take_in;

    assign advance       = r_in_vld && (!r_out_vld || o_report.ready);
    assign i_frame.ready = !r_in_vld || advance;
    assign take_in       = i_frame.valid && i_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take_in) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_cnt <= i_frame.cluster_count;
            r_c1r <= i_frame.c1_row;
            r_c1c <= i_frame.c1_col;
            r_c2r <= i_frame.c2_row;
            r_c2c <= i_frame.c2_col;
            r_c3r <= i_frame.c3_row;
            r_c3c <= i_frame.c3_col;
        end
    end

    // ------------------------------------------------------------------
    // Track state and its update
    // ------------------------------------------------------------------
    t_coord r_t1r, r_t1c, r_t2r, r_t2c;
    t_miss  r_m1, r_m2;
    t_coord n_t1r, n_t1c, n_t2r, n_t2c;
    t_miss  n_m1, n_m2;
    logic   n_line;
    logic [1:0] n_s1, n_s2;

    t_dist  a1, a2, b1, b2, t1, t2;
    t_dist  ma, mb, mt;
    logic   rep_a, rep_b, straight;
    t_coord ar, ac, br, bc;

    // Six distances of the three centroids to the two stored tracks.
    always_comb begin
        a1 = sq_dist(r_c1r, r_c1c, r_t1r, r_t1c);
        a2 = sq_dist(r_c1r, r_c1c, r_t2r, r_t2c);
        b1 = sq_dist(r_c2r, r_c2c, r_t1r, r_t1c);
        b2 = sq_dist(r_c2r, r_c2c, r_t2r, r_t2c);
        t1 = sq_dist(r_c3r, r_c3c, r_t1r, r_t1c);
        t2 = sq_dist(r_c3r, r_c3c, r_t2r, r_t2c);
        ma = min2(a1, a2);
        mb = min2(b1, b2);
        mt = min2(t1, t2);
    end

    // With three centroids the worst-fitting centroid (both, on a tie) is replaced by the third, then pairwise match.
    always_comb begin
        logic  [DIST_W-1:0] x1, x2, y1, y2;
        rep_a = (r_cnt == CNT_THREE) && (ma >= mb) && (ma >= mt);
        rep_b = (r_cnt == CNT_THREE) && (mb >= ma) && (mb >= mt);
        x1 = rep_a ? t1 : a1;
        x2 = rep_a ? t2 : a2;
        y1 = rep_b ? t1 : b1;
        y2 = rep_b ? t2 : b2;
        ar = rep_a ? r_c3r : r_c1r;
        ac = rep_a ? r_c3c : r_c1c;
        br = rep_b ? r_c3r : r_c2r;
        bc = rep_b ? r_c3c : r_c2c;
        priority if (x1 <= y1 && y2 <= x2) begin
            straight = 1'b1;
        end else if (x1 <= y1 && x2 <= y2) begin
            straight = !(x2 <= x1);
        end else if (y1 <= x1 && y2 <= x2) begin
            straight = (y2 <= y1);
        end else begin
            straight = 1'b0;
        end
    end

    // Next track state and report fields, by centroid count.
    always_comb begin
        n_t1r  = r_t1r;
        n_t1c  = r_t1c;
        n_t2r  = r_t2r;
        n_t2c  = r_t2c;
        n_m1   = r_m1;
        n_m2   = r_m2;
        n_line = 1'b0;
        n_s1   = ST_POSITION;
        n_s2   = ST_POSITION;
        priority if (r_cnt == CNT_NONE) begin
            n_m1   = bump(r_m1);
            n_m2   = bump(r_m2);
            n_line = (CMP_W'(n_m1) == CMP_W'(r_thr)) || (CMP_W'(n_m2) == CMP_W'(r_thr));
            n_s1   = miss_status(n_m1, r_thr);
            n_s2   = miss_status(n_m2, r_thr);
        end else if (r_cnt == CNT_ONE) begin
            n_line = 1'b1;
            if (a1 <= a2) begin
                n_t1r = r_c1r;
                n_t1c = r_c1c;
                n_m1  = '0;
                n_m2  = bump(r_m2);
                n_s2  = miss_status(n_m2, r_thr);
            end else begin
                n_t2r = r_c1r;
                n_t2c = r_c1c;
                n_m2  = '0;
                n_m1  = bump(r_m1);
                n_s1  = miss_status(n_m1, r_thr);
            end
        end else if (r_cnt == CNT_TWO || r_cnt == CNT_THREE) begin
            n_line = 1'b1;
            n_m1   = '0;
            n_m2   = '0;
            if (straight) begin
                n_t1r = ar;
                n_t1c = ac;
                n_t2r = br;
                n_t2c = bc;
            end else begin
                n_t1r = br;
                n_t1c = bc;
                n_t2r = ar;
                n_t2c = ac;
            end
        end else begin
            n_line = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1r <= '0;
            r_t1c <= '0;
            r_t2r <= '0;
            r_t2c <= '0;
            r_m1  <= '0;
            r_m2  <= '0;
        end else if (advance) begin
            r_t1r <= n_t1r;
            r_t1c <= n_t1c;
            r_t2r <= n_t2r;
            r_t2c <= n_t2c;
            r_m1  <= n_m1;
            r_m2  <= n_m2;
        end
    end

    // ------------------------------------------------------------------
    // Report register
    // ------------------------------------------------------------------
    logic       r_line;
    logic [1:0] r_s1, r_s2;
    t_coord     r_o1r, r_o1c, r_o2r, r_o2c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (o_report.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // Fields are zero when no line is written.
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_line <= n_line;
            r_s1   <= n_line ? n_s1 : ST_POSITION;
            r_s2   <= n_line ? n_s2 : ST_POSITION;
            r_o1r  <= n_line ? n_t1r : '0;
            r_o1c  <= n_line ? n_t1c : '0;
            r_o2r  <= n_line ? n_t2r : '0;
            r_o2c  <= n_line ? n_t2c : '0;
        end
    end

    assign o_report.valid        = r_out_vld;
    assign o_report.line_written = r_line;
    assign o_report.one_status   = r_s1;
    assign o_report.one_row      = r_o1r;
    assign o_report.one_col      = r_o1c;
    assign o_report.two_status   = r_s2;
    assign o_report.two_row      = r_o2r;
    assign o_report.two_col      = r_o2c;

endmodule

// ----- tb/track_report_checker.sv -----
// ============================================================================
// track_report_checker: track report prediction and comparison
// Watches the frame and report channels and the register port, keeps its own
// copy of both tracks and the lost threshold, and compares every report with
// the one predicted for the oldest unanswered frame.
// ============================================================================
module track_report_checker
    import nta_pkg::*;
#(
    parameter int COORD_WIDTH = 15,
    parameter int MISS_WIDTH  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    nta_frame_if                  i_frame,
    nta_report_if                 i_report,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int DIST_W = 2 * COORD_WIDTH + 1;
    localparam logic [APB_ADDR_W-1:0] THRESHOLD_ADDR = APB_ADDR_W'(4 * REG_LOST_THRESHOLD);

    typedef logic [COORD_WIDTH-1:0] coord_t;
    typedef logic [DIST_W-1:0]      dist_t;
    typedef logic [MISS_WIDTH-1:0]  miss_t;

    typedef struct packed {
        logic       line_written;
        logic [1:0] one_status;
        coord_t     one_row;
        coord_t     one_col;
        logic [1:0] two_status;
        coord_t     two_row;
        coord_t     two_col;
    } track_report_t;

    // Predicted track state and threshold.
    coord_t            one_row_q, one_col_q, two_row_q, two_col_q;
    miss_t             misses_one_q, misses_two_q;
    logic [THR_W-1:0]  lost_thr;
    track_report_t     expected_reports[$];
    int                fail_count = 0;

    function automatic dist_t sq_dist(coord_t r, coord_t c, coord_t tr, coord_t tc);
        dist_t dr, dc;
        dr = (r >= tr) ? dist_t'(r - tr) : dist_t'(tr - r);
        dc = (c >= tc) ? dist_t'(c - tc) : dist_t'(tc - c);
        return dr * dr + dc * dc;
    endfunction

    // Miss counters stop at their all-ones value.
    function automatic miss_t bump(miss_t m);
        return (m == '1) ? m : m + 1'b1;
    endfunction

    function automatic logic [1:0] miss_status(miss_t m);
        if (m == lost_thr) return ST_LOST_NOW;
        return (m > lost_thr) ? ST_MISSING_LONG : ST_MISSING;
    endfunction

    // Updates the track state for one frame and works out its report.
    task automatic predict_track_report(input logic [CNT_W-1:0] cnt,
                                        input coord_t r1, c1, r2, c2, r3, c3,
                                        output track_report_t rep);
        dist_t      a1, a2, b1, b2, t1, t2, ma, mb, mt, d1, d2;
        logic       line, straight;
        logic [1:0] s1, s2;
        line = 1'b0;
        s1   = ST_POSITION;
        s2   = ST_POSITION;
        case (cnt)
            CNT_NONE: begin
                misses_one_q = bump(misses_one_q);
                misses_two_q = bump(misses_two_q);
                if (misses_one_q == lost_thr || misses_two_q == lost_thr) begin
                    line = 1'b1;
                    s1   = miss_status(misses_one_q);
                    s2   = miss_status(misses_two_q);
                end
            end
            CNT_ONE: begin
                d1   = sq_dist(r1, c1, one_row_q, one_col_q);
                d2   = sq_dist(r1, c1, two_row_q, two_col_q);
                line = 1'b1;
                // A tie goes to track one.
                if (d1 <= d2) begin
                    one_row_q    = r1;
                    one_col_q    = c1;
                    misses_one_q = '0;
                    misses_two_q = bump(misses_two_q);
                    s2           = miss_status(misses_two_q);
                end else begin
                    two_row_q    = r1;
                    two_col_q    = c1;
                    misses_two_q = '0;
                    misses_one_q = bump(misses_one_q);
                    s1           = miss_status(misses_one_q);
                end
            end
            CNT_TWO, CNT_THREE: begin
                a1 = sq_dist(r1, c1, one_row_q, one_col_q);
                a2 = sq_dist(r1, c1, two_row_q, two_col_q);
                b1 = sq_dist(r2, c2, one_row_q, one_col_q);
                b2 = sq_dist(r2, c2, two_row_q, two_col_q);
                // With three centroids the worst fits give way to the third,
                // both tests using the original distances.
                if (cnt == CNT_THREE) begin
                    t1 = sq_dist(r3, c3, one_row_q, one_col_q);
                    t2 = sq_dist(r3, c3, two_row_q, two_col_q);
                    ma = (a1 < a2) ? a1 : a2;
                    mb = (b1 < b2) ? b1 : b2;
                    mt = (t1 < t2) ? t1 : t2;
                    if (ma >= mb && ma >= mt) begin
                        a1 = t1; a2 = t2; r1 = r3; c1 = c3;
                    end
                    if (mb >= ma && mb >= mt) begin
                        b1 = t1; b2 = t2; r2 = r3; c2 = c3;
                    end
                end
                if (a1 <= b1 && b2 <= a2) begin
                    straight = 1'b1;
                end else if (a1 <= b1 && a2 <= b2) begin
                    straight = !(a2 <= a1);
                end else if (b1 <= a1 && b2 <= a2) begin
                    straight = (b2 <= b1);
                end else begin
                    straight = 1'b0;
                end
                if (straight) begin
                    one_row_q = r1; one_col_q = c1; two_row_q = r2; two_col_q = c2;
                end else begin
                    one_row_q = r2; one_col_q = c2; two_row_q = r1; two_col_q = c1;
                end
                misses_one_q = '0;
                misses_two_q = '0;
                line         = 1'b1;
            end
            default: ;
        endcase
        rep = '0;
        if (line) begin
            rep.line_written = 1'b1;
            rep.one_status   = s1;
            rep.one_row      = one_row_q;
            rep.one_col      = one_col_q;
            rep.two_status   = s2;
            rep.two_row      = two_row_q;
            rep.two_col      = two_col_q;
        end
    endtask

    function automatic void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $display("%0t: report %s expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // Reports are taken before frames so that a report never meets the frame
    // accepted at the same edge.
    always @(posedge i_clk) begin
        track_report_t want, got;
        if (!i_rst_n) begin
            one_row_q    = '0;
            one_col_q    = '0;
            two_row_q    = '0;
            two_col_q    = '0;
            misses_one_q = '0;
            misses_two_q = '0;
            lost_thr     = LOST_THRESHOLD_RESET;
            expected_reports.delete();
        end else begin
            if (i_report.valid && i_report.ready) begin
                got.line_written = i_report.line_written;
                got.one_status   = i_report.one_status;
                got.one_row      = i_report.one_row;
                got.one_col      = i_report.one_col;
                got.two_status   = i_report.two_status;
                got.two_row      = i_report.two_row;
                got.two_col      = i_report.two_col;
                if (expected_reports.size() == 0) begin
                    $display("%0t: report with no frame waiting, got %h", $time, got);
                    fail_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("line_written", want.line_written, got.line_written);
                    check_field("one_status", want.one_status, got.one_status);
                    check_field("one_row", want.one_row, got.one_row);
                    check_field("one_col", want.one_col, got.one_col);
                    check_field("two_status", want.two_status, got.two_status);
                    check_field("two_row", want.two_row, got.two_row);
                    check_field("two_col", want.two_col, got.two_col);
                end
            end
            if (psel && penable && pwrite && pready && paddr == THRESHOLD_ADDR) begin
                lost_thr = pwdata[THR_W-1:0];
            end
            if (i_frame.valid && i_frame.ready) begin
                predict_track_report(i_frame.cluster_count,
                                     i_frame.c1_row, i_frame.c1_col,
                                     i_frame.c2_row, i_frame.c2_col,
                                     i_frame.c3_row, i_frame.c3_col, want);
                expected_reports.insert(expected_reports.size(), want);
            end
        end
        o_pending    <= expected_reports.size();
        o_fail_count <= fail_count;
    end

endmodule

// ----- tb/testbench.sv -----
// ============================================================================
// testbench: two-target track assigner test
// Drives frames and threshold writes into the block, stalls both channels at
// random, and leaves prediction and comparison to the report checker.
// ============================================================================
module testbench;
    import nta_pkg::*;

    localparam int COORD_W = 15;
    localparam int MISS_W  = 8;

    typedef logic [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = '1;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        coord_t           r1, c1, r2, c2, r3, c3;
    } frame_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int                    fail_count;
    int                    pending;
    bit                    calm;
    int                    frames_by_count[5];
    logic [THR_W-1:0]      thr_plan[6];

    nta_frame_if  #(.COORD_WIDTH(COORD_W)) frame_ch ();
    nta_report_if #(.COORD_WIDTH(COORD_W)) report_ch ();

    two_target_nearest_track_assign_unit #(
        .COORD_WIDTH(COORD_W),
        .MISS_WIDTH (MISS_W)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frame (frame_ch),
        .o_report(report_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    track_report_checker #(
        .COORD_WIDTH(COORD_W),
        .MISS_WIDTH (MISS_W)
    ) i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame     (frame_ch),
        .i_report    (report_ch),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit, far above the slowest correct run.
    initial begin
        #2_000_000;
        $display("two_target_nearest_track_assign_unit: mismatch");
        $finish;
    end

    // Report side: a random stall before each item, none in calm phases.
    initial begin
        int stall;
        report_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                report_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            report_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!report_ch.valid);
        end
    end

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 3))
            0:       return coord_t'($urandom());
            1:       return $urandom_range(0, 1) ? COORD_MAX : coord_t'(0);
            2:       return coord_t'($urandom_range(0, 15));
            default: return coord_t'(16384 + $urandom_range(0, 63));
        endcase
    endfunction

    function automatic frame_t make_frame(logic [CNT_W-1:0] cnt, coord_t r1, coord_t c1,
                                          coord_t r2, coord_t c2, coord_t r3, coord_t c3);
        frame_t f;
        f.count = cnt;
        f.r1 = r1; f.c1 = c1; f.r2 = r2; f.c2 = c2; f.r3 = r3; f.c3 = c3;
        return f;
    endfunction

    function automatic frame_t random_frame();
        frame_t f;
        int     pick;
        pick = $urandom_range(0, 99);
        if (pick < 20)      f.count = CNT_NONE;
        else if (pick < 45) f.count = CNT_ONE;
        else if (pick < 70) f.count = CNT_TWO;
        else if (pick < 90) f.count = CNT_THREE;
        else                f.count = CNT_W'($urandom_range(4, 15));
        f.r1 = rand_coord(); f.c1 = rand_coord();
        f.r2 = rand_coord(); f.c2 = rand_coord();
        f.r3 = rand_coord(); f.c3 = rand_coord();
        // Repeated centroids force ties in the distance comparisons.
        if ($urandom_range(0, 9) == 0) begin
            f.r2 = f.r1; f.c2 = f.c1;
        end
        if ($urandom_range(0, 9) == 0) begin
            f.r3 = f.r2; f.c3 = f.c2;
        end
        return f;
    endfunction

    // Valid stays high from one item to the next unless a gap is drawn.
    task automatic send_frame(input frame_t f);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        frame_ch.cluster_count <= f.count;
        frame_ch.c1_row        <= f.r1;
        frame_ch.c1_col        <= f.c1;
        frame_ch.c2_row        <= f.r2;
        frame_ch.c2_col        <= f.c2;
        frame_ch.c3_row        <= f.r3;
        frame_ch.c3_col        <= f.c3;
        frame_ch.valid         <= 1'b1;
        do @(posedge i_clk); while (!frame_ch.ready);
        frames_by_count[(f.count > CNT_THREE) ? 4 : f.count]++;
    endtask

    // Stops the sender and waits until every report has come back.
    task automatic drain();
        frame_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Setup cycle, then the access cycle that writes the register.
    task automatic write_threshold(input logic [THR_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * REG_LOST_THRESHOLD);
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        frame_ch.valid         <= 1'b0;
        frame_ch.cluster_count <= '0;
        frame_ch.c1_row        <= '0;
        frame_ch.c1_col        <= '0;
        frame_ch.c2_row        <= '0;
        frame_ch.c2_col        <= '0;
        frame_ch.c3_row        <= '0;
        frame_ch.c3_col        <= '0;
        calm = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed frames at the reset threshold of ten.
        send_frame(make_frame(CNT_NONE, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(CNT_ONE, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(CNT_ONE, COORD_MAX, COORD_MAX, 0, 0, 0, 0));
        send_frame(make_frame(CNT_ONE, 0, 0, COORD_MAX, COORD_MAX, 0, 0));
        send_frame(make_frame(CNT_TWO, COORD_MAX, 0, 0, COORD_MAX, 0, 0));
        send_frame(make_frame(CNT_TWO, 100, 100, 100, 100, 0, 0));
        send_frame(make_frame(CNT_THREE, 7, 7, 7, 7, 7, 7));
        send_frame(make_frame(CNT_THREE, 8, 8, 9, 9, COORD_MAX, COORD_MAX));
        send_frame(make_frame(CNT_THREE, COORD_MAX, 0, 10, 10, 12, 12));
        send_frame(make_frame(CNT_W'(4), 1, 2, 3, 4, 5, 6));
        send_frame(make_frame(CNT_W'(15), COORD_MAX, COORD_MAX, COORD_MAX,
                              COORD_MAX, COORD_MAX, COORD_MAX));
        // Empty frames walk both counters up to the threshold and past it.
        repeat (11) send_frame(make_frame(CNT_NONE, 0, 0, 0, 0, 0, 0));
        send_frame(make_frame(CNT_ONE, 12, 12, 0, 0, 0, 0));
        drain();

        // Random phases, each at a threshold of its own.
        thr_plan = '{8'd1, 8'd254, 8'd2, 8'd0, 8'd5, 8'd10};
        thr_plan[3] = THR_W'($urandom_range(3, 253));
        for (int phase = 0; phase < 6; phase++) begin
            write_threshold(thr_plan[phase]);
            calm = (phase % 3 == 1);
            repeat (75) send_frame(random_frame());
            calm = 1'b0;
            drain();
            // Before the last phase, drive both miss counters into saturation.
            if (phase == 4) begin
                write_threshold(8'd254);
                repeat (258) send_frame(make_frame(CNT_NONE, 0, 0, 0, 0, 0, 0));
                repeat (4) send_frame(make_frame(CNT_ONE, rand_coord(), rand_coord(),
                                                 0, 0, 0, 0));
                drain();
            end
        end

        repeat (8) @(posedge i_clk);
        $display("Frames sent: %0d empty, %0d with one centroid, %0d with two, %0d with three,",
                 frames_by_count[0], frames_by_count[1], frames_by_count[2],
                 frames_by_count[3]);
        $display("%0d over-count; thresholds from 1 to 254, miss counters saturated.",
                 frames_by_count[4]);
        if (fail_count == 0) begin
            $display("two_target_nearest_track_assign_unit: match");
        end else begin
            $display("two_target_nearest_track_assign_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/nta_pkg.sv
rtl/nta_frame_if.sv
rtl/nta_report_if.sv
rtl/two_target_nearest_track_assign_unit.sv
tb/track_report_checker.sv
tb/testbench.sv
